/* rtl/lsse_pkg.sv */
// ----------------------------------------------------------------------------
// lsse_pkg
// Shared types and constants for the least-squares slope speed estimator.
// ----------------------------------------------------------------------------
package lsse_pkg;

  localparam int unsigned NPointsDefault = 6;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 24;

  localparam logic [CfgIdxW-1:0] REG_SOURCE_FREQUENCY = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_REFERENCE_SPEED = 1'd1;

  localparam logic [15:0] SourceFrequencyReset = 16'd40000;
  localparam logic [23:0] ReferenceSpeedReset = 24'd87903;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_NO_SPREAD = 2'd1;
  localparam logic [1:0] STATUS_ZERO_SLOPE = 2'd2;

  // divider widths
  localparam int unsigned DivNumW = 64;
  localparam int unsigned DivDenW = 64;
  localparam int unsigned DivStepsW = 7;

  typedef enum logic [3:0] {
    ST_ACCUM,
    ST_MUL,
    ST_DIFF,
    ST_CHECK,
    ST_DIV_SLOPE,
    ST_DIV_SPEED,
    ST_ERR_PREP,
    ST_DIV_ERR,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ACCUM,
    OP_MUL,
    OP_DIFF,
    OP_START_SLOPE,
    OP_START_SPEED,
    OP_ERR_PREP,
    OP_START_ERR
  } op_t;

  typedef struct packed {
    op_t  op;
    logic div_step;
    logic load_out;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic last_pair;
    logic den_zero;
    logic slope_zero;
    logic div_done;
  } status_t;

endpackage

/* rtl/lsse_if.sv */
// ----------------------------------------------------------------------------
// lsse_in_if / lsse_out_if
// Valid/ready channels for pairs in and fit results out.
// ----------------------------------------------------------------------------
interface lsse_in_if;
  logic               valid;
  logic               ready;
  logic signed [19:0] velocity;
  logic        [23:0] frequency;
  modport source (output valid, velocity, frequency, input ready);
  modport sink (input valid, velocity, frequency, output ready);
endinterface

interface lsse_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] slope;
  logic signed [31:0] speed_estimate;
  logic        [15:0] relative_error;
  logic        [1:0]  fit_status;
  modport source (output valid, slope, speed_estimate, relative_error, fit_status,
                  input ready);
  modport sink (input valid, slope, speed_estimate, relative_error, fit_status,
                output ready);
endinterface

/* rtl/lsse_div.sv */
// ----------------------------------------------------------------------------
// lsse_div
// Restoring divider, one quotient bit per cycle while step is high: min(num*2^16/den, cap).
// ----------------------------------------------------------------------------
module lsse_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [lsse_pkg::DivNumW-1:0]  num,
  input  logic [lsse_pkg::DivDenW-1:0]  den,
  input  logic [31:0]                   cap,
  input  logic                          step,
  output logic                          done,
  output logic [31:0]                   quot
);
  // dividend is num<<16; 80 bits, iterate over all
  localparam int unsigned DW = lsse_pkg::DivNumW + 16;

  logic [DW-1:0]                   dvd;
  logic [lsse_pkg::DivDenW:0]      rem;
  logic [lsse_pkg::DivDenW-1:0]    dreg;
  logic [32:0]                     q;
  logic [31:0]                     capr;
  logic [lsse_pkg::DivStepsW-1:0]  cnt;
  logic                            busy;
  logic                            sat;

  logic [lsse_pkg::DivDenW:0] rsh;
  logic [33:0]                qn;

  always_comb begin
    rsh = {rem[lsse_pkg::DivDenW-1:0], dvd[DW-1]};
    qn  = {q, 1'b0};
    if (rsh >= {1'b0, dreg}) begin
      rsh   = rsh - {1'b0, dreg};
      qn[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= lsse_pkg::DivStepsW'(DW - 1);
      dvd  <= {num, 16'd0};
      rem  <= '0;
      dreg <= den;
      q    <= '0;
      capr <= cap;
      sat  <= 1'b0;
    end else if (busy && step) begin
      dvd <= dvd << 1;
      rem <= rsh;
      if (qn[33:32] != 2'b00 || qn[31:0] > capr) begin
        sat <= 1'b1;
      end
      q <= qn[32:0];
      if (cnt == '0) begin
        busy <= 1'b0;
      end
      cnt <= cnt - 1'b1;
    end
  end

  assign done = !busy;
  assign quot = sat ? capr : (q[32] ? capr : q[31:0]);
endmodule

/* rtl/lsse_datapath.sv */
// ----------------------------------------------------------------------------
// lsse_datapath
// Running sums, fit numerator/denominator, three divisions, output register.
// ----------------------------------------------------------------------------
module lsse_datapath #(
  parameter int unsigned N_POINTS = lsse_pkg::NPointsDefault
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lsse_pkg::cmd_t        cmd,
  output lsse_pkg::status_t     sts,
  input  logic signed [19:0]    velocity,
  input  logic        [23:0]    frequency,
  input  logic        [15:0]    source_frequency,
  input  logic        [23:0]    reference_speed,
  output logic signed [31:0]    slope,
  output logic signed [31:0]    speed_estimate,
  output logic        [15:0]    relative_error,
  output logic        [1:0]     fit_status
);
  localparam logic [4:0] NP = 5'(N_POINTS);

  logic        [4:0]  pair_count;
  logic signed [23:0] sum_velocity;
  logic        [27:0] sum_frequency;
  logic        [43:0] sum_velocity_squared;
  logic signed [47:0] sum_velocity_frequency;

  logic signed [52:0] n_svf, sv_sf, n_svv, sv_sv;
  logic signed [63:0] num, den;
  logic               neg;
  logic [31:0]        q_slope, q_speed;
  logic signed [32:0] diff;

  logic               d_start;
  logic [63:0]        d_num, d_den;
  logic [31:0]        d_cap, d_q;
  logic               d_done;

  logic signed [44:0] vf;
  logic        [39:0] vv;
  assign vf = 45'(velocity) * $signed({1'b0, frequency});
  assign vv = $unsigned(40'(velocity) * 40'(velocity));

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      pair_count             <= '0;
      sum_velocity           <= '0;
      sum_frequency          <= '0;
      sum_velocity_squared   <= '0;
      sum_velocity_frequency <= '0;
    end else if (cmd.op == lsse_pkg::OP_ACCUM) begin
      pair_count             <= pair_count + 5'd1;
      sum_velocity           <= sum_velocity + 24'(velocity);
      sum_frequency          <= sum_frequency + 28'(frequency);
      sum_velocity_squared   <= sum_velocity_squared + 44'(vv);
      sum_velocity_frequency <= sum_velocity_frequency + 48'(vf);
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      lsse_pkg::OP_MUL: begin
        n_svf <= 53'(sum_velocity_frequency) * $signed({48'd0, NP});
        sv_sf <= 53'(sum_velocity) * $signed({25'd0, sum_frequency});
        n_svv <= $signed({9'd0, sum_velocity_squared}) * $signed({48'd0, NP});
        sv_sv <= 53'(sum_velocity) * 53'(sum_velocity);
      end
      lsse_pkg::OP_DIFF: begin
        num <= 64'(n_svf - sv_sf);
        den <= 64'(n_svv - sv_sv);
        neg <= (n_svf - sv_sf) < 0;
      end
      lsse_pkg::OP_START_SPEED: q_slope <= d_q;
      lsse_pkg::OP_ERR_PREP: begin
        q_speed <= d_q;
        diff    <= (neg ? -$signed({1'b0, d_q}) : $signed({1'b0, d_q}))
                   - $signed({9'd0, reference_speed});
      end
      default: ;
    endcase
  end

  always_comb begin
    d_start = 1'b0;
    d_num   = '0;
    d_den   = '0;
    d_cap   = '0;
    unique case (cmd.op)
      lsse_pkg::OP_START_SLOPE: begin
        d_start = 1'b1;
        d_num   = neg ? -num : num;
        d_den   = den;
        d_cap   = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
      lsse_pkg::OP_START_SPEED: begin
        d_start = 1'b1;
        d_num   = 64'(source_frequency);
        d_den   = 64'(d_q);
        d_cap   = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
      lsse_pkg::OP_START_ERR: begin
        d_start = 1'b1;
        d_num   = 64'(diff < 0 ? -diff : diff);
        d_den   = 64'(reference_speed);
        d_cap   = 32'h0000_FFFF;
      end
      default: ;
    endcase
  end

  lsse_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(d_start),
    .num  (d_num),
    .den  (d_den),
    .cap  (d_cap),
    .step (cmd.div_step),
    .done (d_done),
    .quot (d_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (den <= 0) begin
        slope <= '0; speed_estimate <= '0; relative_error <= '0;
        fit_status <= lsse_pkg::STATUS_NO_SPREAD;
      end else if (q_slope == '0) begin
        slope <= '0; speed_estimate <= '0; relative_error <= '0;
        fit_status <= lsse_pkg::STATUS_ZERO_SLOPE;
      end else begin
        slope          <= neg ? -q_slope : q_slope;
        speed_estimate <= neg ? -q_speed : q_speed;
        relative_error <= (reference_speed == '0) ? 16'hFFFF : d_q[15:0];
        fit_status     <= lsse_pkg::STATUS_OK;
      end
    end
  end

  assign sts.last_pair  = (pair_count == NP - 5'd1);
  assign sts.den_zero   = (den <= 0);
  assign sts.slope_zero = (d_q == '0);
  assign sts.div_done   = d_done;
endmodule

/* rtl/lsse_ctrl.sv */
// ----------------------------------------------------------------------------
// lsse_ctrl
// Sequencer: accumulate pairs, then form the fit and run the divisions.
// ----------------------------------------------------------------------------
module lsse_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  lsse_pkg::status_t sts,
  output lsse_pkg::cmd_t    cmd
);
  lsse_pkg::state_t state, state_next;
  logic             ovalid, ovalid_next;
  logic             started;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= lsse_pkg::ST_ACCUM;
      ovalid  <= 1'b0;
      started <= 1'b0;
    end else begin
      state   <= state_next;
      ovalid  <= ovalid_next;
      started <= (state_next == state) && state != lsse_pkg::ST_ACCUM;
    end
  end

  always_comb begin
    state_next  = state;
    ovalid_next = ovalid && !out_ready;
    cmd         = '{op: lsse_pkg::OP_NONE, div_step: 1'b1, load_out: 1'b0, clear: 1'b0};
    in_ready    = 1'b0;
    unique case (state)
      lsse_pkg::ST_ACCUM: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = lsse_pkg::OP_ACCUM;
          if (sts.last_pair) state_next = lsse_pkg::ST_MUL;
        end
      end
      lsse_pkg::ST_MUL: begin
        cmd.op = lsse_pkg::OP_MUL;
        state_next = lsse_pkg::ST_DIFF;
      end
      lsse_pkg::ST_DIFF: begin
        cmd.op = lsse_pkg::OP_DIFF;
        cmd.clear = 1'b1;
        state_next = lsse_pkg::ST_CHECK;
      end
      lsse_pkg::ST_CHECK: begin
        if (sts.den_zero) begin
          state_next = lsse_pkg::ST_OUT;
        end else begin
          cmd.op = lsse_pkg::OP_START_SLOPE;
          state_next = lsse_pkg::ST_DIV_SLOPE;
        end
      end
      lsse_pkg::ST_DIV_SLOPE: begin
        if (started && sts.div_done) begin
          if (sts.slope_zero) begin
            cmd.op = lsse_pkg::OP_START_SPEED;
            cmd.div_step = 1'b0;
            state_next = lsse_pkg::ST_OUT;
          end else begin
            cmd.op = lsse_pkg::OP_START_SPEED;
            state_next = lsse_pkg::ST_DIV_SPEED;
          end
        end
      end
      lsse_pkg::ST_DIV_SPEED: begin
        if (started && sts.div_done) begin
          cmd.op = lsse_pkg::OP_ERR_PREP;
          state_next = lsse_pkg::ST_ERR_PREP;
        end
      end
      lsse_pkg::ST_ERR_PREP: begin
        cmd.op = lsse_pkg::OP_START_ERR;
        state_next = lsse_pkg::ST_DIV_ERR;
      end
      lsse_pkg::ST_DIV_ERR: begin
        if (started && sts.div_done) state_next = lsse_pkg::ST_OUT;
      end
      lsse_pkg::ST_OUT: begin
        if (!ovalid || out_ready) begin
          cmd.load_out = 1'b1;
          ovalid_next = 1'b1;
          state_next = lsse_pkg::ST_ACCUM;
        end
      end
      default: state_next = lsse_pkg::ST_ACCUM;
    endcase
  end

  assign out_valid = ovalid;

`ifndef NO_ASSERTIONS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != lsse_pkg::ST_ACCUM |-> !in_ready)
    else $error("input taken while computing");
  a_load_from_out: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("result loaded but not shown");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("pending result overwritten");
`endif
endmodule

/* rtl/least_squares_slope_speed_estimate.sv */
// ----------------------------------------------------------------------------
// least_squares_slope_speed_estimate
// Least-squares slope fit over N_POINTS pairs with speed and error estimate.
// ----------------------------------------------------------------------------
// Pairs are taken one per cycle. After the N_POINTS-th pair the block stops
// accepting until the result is loaded, and longer while the previous result
// still waits at the output: the MUL, DIFF and CHECK states form and check
// the fit terms, then a single shared radix-2 divider runs three 80-step
// divisions (slope, speed, error; none with no velocity spread, only the slope
// one on a zero slope), and the OUT state loads the output register.
// A pending result sits in an output register while the next set accumulates.
module least_squares_slope_speed_estimate #(
  parameter int unsigned N_POINTS = lsse_pkg::NPointsDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  lsse_in_if.sink                       in_ch,
  lsse_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [lsse_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [lsse_pkg::CfgDataW-1:0] cfg_data
);
  logic [15:0]       source_frequency;
  logic [23:0]       reference_speed;
  lsse_pkg::cmd_t    cmd;
  lsse_pkg::status_t sts;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_frequency <= lsse_pkg::SourceFrequencyReset;
      reference_speed  <= lsse_pkg::ReferenceSpeedReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lsse_pkg::REG_SOURCE_FREQUENCY: source_frequency <= cfg_data[15:0];
        lsse_pkg::REG_REFERENCE_SPEED:  reference_speed  <= cfg_data;
        default: ;
      endcase
    end
  end

  lsse_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lsse_datapath #(.N_POINTS(N_POINTS)) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .velocity        (in_ch.velocity),
    .frequency       (in_ch.frequency),
    .source_frequency(source_frequency),
    .reference_speed (reference_speed),
    .slope           (out_ch.slope),
    .speed_estimate  (out_ch.speed_estimate),
    .relative_error  (out_ch.relative_error),
    .fit_status      (out_ch.fit_status)
  );
endmodule
